// ===== src/assert_macros.svh =====
// assertion helpers used by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rhp_pkg.sv =====
`timescale 1ns / 1ps

package rhp_pkg;

	// byte counter width and header arithmetic width
	localparam int IDX_W = 16;
	localparam int HDR_W = 19;
	localparam int MAX_PACKET_BYTES_DEF = 65535;

	// header layout
	localparam logic [HDR_W-1:0] BASE_HDR_BYTES = HDR_W'(12);
	localparam logic [HDR_W-1:0] WORD_BYTES     = HDR_W'(4);
	localparam logic [HDR_W-1:0] EXT_LEN_OFS    = HDR_W'(2);
	localparam logic [1:0]       RTP_VERSION    = 2'd2;

	// fields frozen at the last byte of a packet
	typedef struct packed {
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [15:0]      seq;
		logic [31:0]      ts;
		logic [31:0]      ssrc;
		logic [15:0]      ext;
		logic [IDX_W-1:0] len;
		logic             ovf;
	} snap_t;

	// one parse result
	typedef struct packed {
		logic        ok;
		logic        padding;
		logic        extension;
		logic [3:0]  csrc_count;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] sequence_res;
		logic [31:0] timestamp;
		logic [31:0] ssrc;
		logic [15:0] header_length;
		logic [15:0] payload_size;
	} res_t;

	// fixed header plus csrc list
	function automatic logic [HDR_W-1:0] base_len(input logic [3:0] cc);
		base_len = BASE_HDR_BYTES + {{(HDR_W-6){1'b0}}, cc, 2'b00};
	endfunction

endpackage

// ===== src/rhp_capture.sv =====
`timescale 1ns / 1ps

module rhp_capture import rhp_pkg::*; #(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pkt_valid,
	output logic       pkt_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       snap_valid,
	output snap_t      snap,
	input  logic       snap_take
);

	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PACKET_BYTES);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic             s1_go;
	logic             pkt_acc;

	logic [IDX_W-1:0] idx_q, idx_d;
	logic             ovf_q, ovf_d;
	logic [15:0]      first_q, first_d;
	logic [15:0]      seq_q, seq_d;
	logic [31:0]      ts_q, ts_d;
	logic [31:0]      ssrc_q, ssrc_d;
	logic [15:0]      ext_q, ext_d;
	logic [HDR_W-1:0] base;
	logic [HDR_W-1:0] pos;

	logic             snap_valid_s2;
	snap_t            snap_s2;

	// s1 drains unless a finished packet waits on a full snapshot stage
	assign s1_go     = !last_s1 || !snap_valid_s2 || snap_take;
	assign pkt_stall = valid_s1 && !s1_go;
	assign pkt_acc   = pkt_valid && !pkt_stall;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// field capture by byte position
	always_comb begin
		idx_d   = idx_q;
		ovf_d   = ovf_q;
		first_d = first_q;
		seq_d   = seq_q;
		ts_d    = ts_q;
		ssrc_d  = ssrc_q;
		ext_d   = ext_q;
		base    = base_len(first_q[11:8]);
		pos     = HDR_W'(idx_q);
		if (ovf_q || idx_q >= MAX_IDX) begin
			ovf_d = 1'b1;
		end else begin
			idx_d = idx_q + IDX_W'(1);
			if (idx_q < IDX_W'(2)) begin
				first_d = {first_q[7:0], data_s1};
			end else if (idx_q < IDX_W'(4)) begin
				seq_d = {seq_q[7:0], data_s1};
			end else if (idx_q < IDX_W'(8)) begin
				ts_d = {ts_q[23:0], data_s1};
			end else if (idx_q < IDX_W'(12)) begin
				ssrc_d = {ssrc_q[23:0], data_s1};
			end else if (pos == base + EXT_LEN_OFS || pos == base + EXT_LEN_OFS + HDR_W'(1)) begin
				ext_d = {ext_q[7:0], data_s1};
			end
		end
	end

	// packet state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			first_q <= '0;
			seq_q   <= '0;
			ts_q    <= '0;
			ssrc_q  <= '0;
			ext_q   <= '0;
		end else if (valid_s1 && s1_go) begin
			if (last_s1) begin
				idx_q   <= '0;
				ovf_q   <= 1'b0;
				first_q <= '0;
				seq_q   <= '0;
				ts_q    <= '0;
				ssrc_q  <= '0;
				ext_q   <= '0;
			end else begin
				idx_q   <= idx_d;
				ovf_q   <= ovf_d;
				first_q <= first_d;
				seq_q   <= seq_d;
				ts_q    <= ts_d;
				ssrc_q  <= ssrc_d;
				ext_q   <= ext_d;
			end
		end
	end

	// snapshot stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (valid_s1 && s1_go && last_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (snap_take) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	// snapshot stage payload
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_go && last_s1) begin
			snap_s2.b0   <= first_d[15:8];
			snap_s2.b1   <= first_d[7:0];
			snap_s2.seq  <= seq_d;
			snap_s2.ts   <= ts_d;
			snap_s2.ssrc <= ssrc_d;
			snap_s2.ext  <= ext_d;
			snap_s2.len  <= idx_d;
			snap_s2.ovf  <= ovf_d;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

// ===== src/rhp_result.sv =====
`timescale 1ns / 1ps

module rhp_result import rhp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  snap_valid,
	input  snap_t snap,
	output logic  snap_take,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	logic             res_valid_q;
	res_t             res_q;
	res_t             res_d;
	logic [HDR_W-1:0] len;
	logic [HDR_W-1:0] base;
	logic [HDR_W-1:0] ext_hdr;
	logic [HDR_W-1:0] hdr;
	logic [HDR_W-1:0] pay;
	logic             ok_pre;
	logic             ok;

	assign snap_take = snap_valid && (!res_valid_q || !res_stall);

	// header length and error checks
	always_comb begin
		len     = HDR_W'(snap.len);
		base    = base_len(snap.b0[3:0]);
		ext_hdr = base + WORD_BYTES + {1'b0, snap.ext, 2'b00};
		ok_pre  = !snap.ovf && len >= BASE_HDR_BYTES && snap.b0[7:6] == RTP_VERSION;
		if (ok_pre && snap.b0[4] && len > base + WORD_BYTES) begin
			hdr = ext_hdr;
		end else begin
			hdr = base;
		end
		ok  = ok_pre && hdr < len;
		pay = len - hdr;

		res_d = '0;
		if (ok) begin
			res_d.ok            = 1'b1;
			res_d.padding       = snap.b0[5];
			res_d.extension     = snap.b0[4];
			res_d.csrc_count    = snap.b0[3:0];
			res_d.marker        = snap.b1[7];
			res_d.payload_type  = snap.b1[6:0];
			res_d.sequence_res  = snap.seq;
			res_d.timestamp     = snap.ts;
			res_d.ssrc          = snap.ssrc;
			res_d.header_length = hdr[15:0];
			res_d.payload_size  = pay[15:0];
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (snap_take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (snap_take) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== src/rtp_header_parser.sv =====
// channel  | handshake            | payload
// packet   | pkt_valid/pkt_stall  | data_byte, last_byte
// result   | res_valid/res_stall  | ok .. payload_size
//
// one byte is taken every cycle while pkt_stall is low; after the last byte, a result passes
// through the input register, snapshot register and result register
// arst_n clears all control and packet state; payload registers hold no reset
// a waiting result stalls the snapshot, which stalls the input only on a last byte
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtp_header_parser import rhp_pkg::*; #(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        ok,
	output logic        padding,
	output logic        extension,
	output logic [3:0]  csrc_count,
	output logic        marker,
	output logic [6:0]  payload_type,
	output logic [15:0] sequence_res,
	output logic [31:0] timestamp,
	output logic [31:0] ssrc,
	output logic [15:0] header_length,
	output logic [15:0] payload_size
);

	logic  snap_valid;
	logic  snap_take;
	snap_t snap;
	res_t  res;

	// byte capture and packet snapshot
	rhp_capture #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.snap_valid(snap_valid),
		.snap      (snap),
		.snap_take (snap_take)
	);

	// header checks and result register
	rhp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_valid(snap_valid),
		.snap      (snap),
		.snap_take (snap_take),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign ok            = res.ok;
	assign padding       = res.padding;
	assign extension     = res.extension;
	assign csrc_count    = res.csrc_count;
	assign marker        = res.marker;
	assign payload_type  = res.payload_type;
	assign sequence_res  = res.sequence_res;
	assign timestamp     = res.timestamp;
	assign ssrc          = res.ssrc;
	assign header_length = res.header_length;
	assign payload_size  = res.payload_size;

	// failed parse carries an all-zero result
	`ASSERT_IMPL(a_err_zero, clk, arst_n, res_valid && !ok, header_length == 16'd0 && payload_size == 16'd0 && ssrc == 32'd0, "error result not cleared")
	// good header covers the fixed part and csrc list
	`ASSERT_IMPL(a_hdr_min, clk, arst_n, res_valid && ok, header_length >= 16'd12 + {10'd0, csrc_count, 2'b00}, "header length below csrc list")
	// a snapshot transfer always fills the result register
	`ASSERT_NEXT(a_take_fill, clk, arst_n, snap_take, res_valid, "snapshot transfer lost")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import rhp_pkg::*;

	// one directed packet: header bytes, length, extension word, fill byte, random flag, fixed flag and expected result
	typedef struct {
		logic [7:0]  b0;
		logic [7:0]  b1;
		int unsigned len;
		logic [15:0] ext_len;
		logic [7:0]  fill;
		bit          rnd;
		bit          fixed;
		res_t        val;
	} pkt_row_t;

	// per packet: take the typed result or the parsed one
	typedef struct {
		bit   fixed;
		res_t val;
	} pkt_note_t;

	localparam res_t HDR_ERROR = '0;
	localparam res_t MIN_OK    = '{ok: 1'b1, header_length: 16'd12, payload_size: 16'd1,
		default: '0};
	localparam int RAND_BYTES = 1250;
	localparam int QUIET_FROM = 1000;

	logic        clk;
	logic        arst_n;
	logic        pkt_valid;
	logic        pkt_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        res_valid;
	logic        res_stall;
	logic        ok;
	logic        padding;
	logic        extension;
	logic [3:0]  csrc_count;
	logic        marker;
	logic [6:0]  payload_type;
	logic [15:0] sequence_res;
	logic [31:0] timestamp;
	logic [31:0] ssrc;
	logic [15:0] header_length;
	logic [15:0] payload_size;

	// header parse state, mirrored from the block
	int unsigned rx_count    = 0;
	bit          rx_overflow = 1'b0;
	logic [15:0] lead_bytes  = '0;
	logic [15:0] seq_acc     = '0;
	logic [31:0] ts_acc      = '0;
	logic [31:0] ssrc_acc    = '0;
	logic [15:0] ext_acc     = '0;

	res_t      expected_results[$];
	pkt_note_t packet_notes[$];

	int unsigned mismatches     = 0;
	int unsigned results_seen   = 0;
	int unsigned results_ok     = 0;
	int unsigned sent_bytes     = 0;
	int unsigned sent_packets   = 0;
	int unsigned gap_div        = 0;
	bit          quiet          = 1'b0;

	pkt_row_t directed_rows [17] = '{
		'{8'hFF, 8'hFF, 1,     16'h0000, 8'h00, 1'b0, 1'b1, HDR_ERROR}, // lone byte
		'{8'h80, 8'h00, 11,    16'h0000, 8'hFF, 1'b0, 1'b1, HDR_ERROR}, // one byte short
		'{8'h00, 8'h00, 20,    16'h0000, 8'h00, 1'b1, 1'b1, HDR_ERROR}, // version 0
		'{8'h7F, 8'hFF, 20,    16'h0000, 8'h00, 1'b1, 1'b1, HDR_ERROR}, // version 1
		'{8'hC0, 8'h00, 20,    16'h0000, 8'h00, 1'b1, 1'b1, HDR_ERROR}, // version 3
		'{8'h80, 8'h00, 12,    16'h0000, 8'hFF, 1'b0, 1'b1, HDR_ERROR}, // no payload
		'{8'h80, 8'h00, 13,    16'h0000, 8'h00, 1'b0, 1'b1, MIN_OK},
		'{8'h80, 8'hFF, 13,    16'h0000, 8'hFF, 1'b0, 1'b0, HDR_ERROR},
		'{8'hBF, 8'hFF, 76,    16'h0000, 8'hFF, 1'b0, 1'b0, HDR_ERROR}, // ext just too short
		'{8'h8F, 8'h00, 72,    16'h0000, 8'h00, 1'b0, 1'b1, HDR_ERROR}, // csrc list fills packet
		'{8'h90, 8'h7F, 16,    16'h0000, 8'h00, 1'b1, 1'b0, HDR_ERROR},
		'{8'h90, 8'h80, 17,    16'h0000, 8'h00, 1'b1, 1'b0, HDR_ERROR},
		'{8'h90, 8'h00, 20,    16'h0001, 8'h00, 1'b1, 1'b1, HDR_ERROR}, // ext fills packet
		'{8'h90, 8'h00, 21,    16'h0001, 8'h00, 1'b1, 1'b0, HDR_ERROR},
		'{8'h90, 8'h00, 30,    16'hFFFF, 8'h00, 1'b1, 1'b1, HDR_ERROR}, // huge ext length
		'{8'hBC, 8'h5A, 100,   16'h0002, 8'h00, 1'b1, 1'b0, HDR_ERROR},
		'{8'hA0, 8'h81, 40,    16'h0000, 8'h00, 1'b1, 1'b0, HDR_ERROR}
	};

	rtp_header_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pkt_valid     (pkt_valid),
		.pkt_stall     (pkt_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.ok            (ok),
		.padding       (padding),
		.extension     (extension),
		.csrc_count    (csrc_count),
		.marker        (marker),
		.payload_type  (payload_type),
		.sequence_res  (sequence_res),
		.timestamp     (timestamp),
		.ssrc          (ssrc),
		.header_length (header_length),
		.payload_size  (payload_size)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one accepted byte into the header state; the last byte queues a result
	task automatic parse_byte(input logic [7:0] b, input logic lst);
		int unsigned base;
		int unsigned hdr;
		int unsigned len;
		logic [7:0]  b0;
		logic [7:0]  b1;
		bit          good;
		res_t        r;
		pkt_note_t   note;

		// capture by position, dropping bytes past the maximum length
		if (rx_overflow || rx_count >= MAX_PACKET_BYTES_DEF) begin
			rx_overflow = 1'b1;
		end else begin
			base = 12 + 4 * lead_bytes[11:8];
			if (rx_count < 2)
				lead_bytes = {lead_bytes[7:0], b};
			else if (rx_count < 4)
				seq_acc = {seq_acc[7:0], b};
			else if (rx_count < 8)
				ts_acc = {ts_acc[23:0], b};
			else if (rx_count < 12)
				ssrc_acc = {ssrc_acc[23:0], b};
			else if (rx_count == base + 2 || rx_count == base + 3)
				ext_acc = {ext_acc[7:0], b};
			rx_count = rx_count + 1;
		end
		if (!lst)
			return;

		// header length and validity at the packet end
		len  = rx_count;
		b0   = lead_bytes[15:8];
		b1   = lead_bytes[7:0];
		hdr  = 12 + 4 * b0[3:0];
		good = !rx_overflow && len >= 12 && b0[7:6] == 2'd2;
		if (good && b0[4] && len > hdr + 4)
			hdr = hdr + 4 + 4 * ext_acc;
		if (hdr >= len)
			good = 1'b0;
		r = '0;
		if (good) begin
			r.ok            = 1'b1;
			r.padding       = b0[5];
			r.extension     = b0[4];
			r.csrc_count    = b0[3:0];
			r.marker        = b1[7];
			r.payload_type  = b1[6:0];
			r.sequence_res  = seq_acc;
			r.timestamp     = ts_acc;
			r.ssrc          = ssrc_acc;
			r.header_length = 16'(hdr);
			r.payload_size  = 16'(len - hdr);
		end
		if (packet_notes.size() != 0) begin
			note = packet_notes.pop_front();
			if (note.fixed)
				r = note.val;
		end
		expected_results.push_back(r);

		// back to the reset state for the next packet
		rx_count    = 0;
		rx_overflow = 1'b0;
		lead_bytes  = '0;
		seq_acc     = '0;
		ts_acc      = '0;
		ssrc_acc    = '0;
		ext_acc     = '0;
	endtask

	// predict on every accepted byte
	always @(posedge clk) begin
		if (arst_n && pkt_valid && !pkt_stall)
			parse_byte(data_byte, last_byte);
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no packet outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("ok", 32'(want.ok), 32'(ok));
				check_field("padding", 32'(want.padding), 32'(padding));
				check_field("extension", 32'(want.extension), 32'(extension));
				check_field("csrc_count", 32'(want.csrc_count), 32'(csrc_count));
				check_field("marker", 32'(want.marker), 32'(marker));
				check_field("payload_type", 32'(want.payload_type), 32'(payload_type));
				check_field("sequence_res", 32'(want.sequence_res), 32'(sequence_res));
				check_field("timestamp", want.timestamp, timestamp);
				check_field("ssrc", want.ssrc, ssrc);
				check_field("header_length", 32'(want.header_length), 32'(header_length));
				check_field("payload_size", 32'(want.payload_size), 32'(payload_size));
				results_seen++;
				if (want.ok)
					results_ok++;
			end
		end
	end

	// result side back-pressure in random bursts, off in the quiet tail
	initial begin : result_sink
		int unsigned hold;
		int unsigned window;
		int unsigned div;
		hold      = 0;
		window    = 0;
		div       = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (window == 0) begin
				window = 200;
				div    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
			end
			window--;
			if (quiet || !arst_n)
				hold = 0;
			else if (hold != 0)
				hold--;
			else if (div != 0 && $urandom_range(1, div) == 1)
				hold = $urandom_range(1, 19);
			res_stall <= (hold != 0);
		end
	end

	// one byte transfer, with an optional gap in front of it
	task automatic drive_byte(input logic [7:0] b, input logic lst);
		if (gap_div != 0 && $urandom_range(1, gap_div) == 1) begin
			pkt_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pkt_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (pkt_stall !== 1'b0);
	endtask

	// build a packet on the fly: two lead bytes, extension word in place, random or fill bytes elsewhere
	task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
		input int unsigned len, input logic [15:0] ext_len, input logic [7:0] fill,
		input bit rnd, input bit fixed, input res_t val);
		int unsigned base;
		int unsigned i;
		logic [7:0]  b;
		pkt_note_t   note;
		base       = 12 + 4 * b0[3:0];
		note.fixed = fixed;
		note.val   = val;
		packet_notes.push_back(note);
		gap_div = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
		for (i = 0; i < len; i++) begin
			if (i == 0)
				b = b0;
			else if (i == 1)
				b = b1;
			else if (i == base + 2)
				b = ext_len[15:8];
			else if (i == base + 3)
				b = ext_len[7:0];
			else if (rnd)
				b = 8'($urandom);
			else
				b = fill;
			drive_byte(b, i == len - 1);
		end
		sent_bytes += len;
		sent_packets++;
	endtask

	// stimulus
	initial begin : packet_source
		int unsigned rand_bytes;
		int unsigned cc;
		int unsigned base;
		int unsigned len;
		int unsigned wait_cnt;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [15:0] ext_len;

		arst_n     = 1'b0;
		pkt_valid  = 1'b0;
		data_byte  = '0;
		last_byte  = 1'b0;
		rand_bytes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets
		foreach (directed_rows[k])
			send_packet(directed_rows[k].b0, directed_rows[k].b1, directed_rows[k].len,
				directed_rows[k].ext_len, directed_rows[k].fill, directed_rows[k].rnd,
				directed_rows[k].fixed, directed_rows[k].val);

		// random packets, mostly version 2 with lengths around the header size
		while (rand_bytes < RAND_BYTES) begin
			if (rand_bytes >= QUIET_FROM)
				quiet = 1'b1;
			cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
			ext_len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
			b1 = 8'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				b0  = 8'($urandom);
				len = $urandom_range(1, 40);
			end else begin
				b0   = {2'b10, 2'($urandom), 4'(cc)};
				base = 12 + 4 * cc;
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(1, base + 4);
				else
					len = base + $urandom_range(0, 24);
			end
			send_packet(b0, b1, len, ext_len, 8'h00, 1'b1, 1'b0, HDR_ERROR);
			rand_bytes += len;
		end
		pkt_valid <= 1'b0;

		// drain the outstanding results
		for (wait_cnt = 0; expected_results.size() != 0 && wait_cnt < 1000; wait_cnt++)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatches++;
		end

		$display("%0d packets, %0d bytes sent; %0d results compared, %0d of them valid headers",
			sent_packets, sent_bytes, results_seen, results_ok);
		$display("covered short, bad version, header at end and extension packets");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#100000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/rhp_pkg.sv
src/rhp_capture.sv
src/rhp_result.sv
src/rtp_header_parser.sv
tb/sv/testbench.sv
